/* src/ocx_pkg.sv */
// Shared types and constants for the order crossover block.
// Depends on nothing; imported by the sequencer and the top level.
`default_nettype none

package ocx_pkg;

  localparam int unsigned GENE_W     = 6;
  localparam int unsigned PAIR_W     = 2 * GENE_W;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned CHANCE_W   = 16;
  localparam int unsigned THR_W      = 17;
  localparam int unsigned TOTAL_W    = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned GENE_SLOTS = 2 ** GENE_W;

  localparam logic [CFG_IDX_W-1:0] REG_GENE_COUNT      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CROSS_THRESHOLD = CFG_IDX_W'(1);

  localparam logic [CNT_W-1:0] GENE_COUNT_RESET = CNT_W'(64);
  localparam logic [THR_W-1:0] THRESHOLD_RESET  = THR_W'(58982);

  // Work handed to the sequencer when the last gene pair of a parent set lands.
  typedef struct packed {
    logic              crossed;
    logic [CNT_W-1:0]  count;
    logic [GENE_W-1:0] lo;
    logic [GENE_W-1:0] hi;
  } ocx_cmd_t;

  // One child gene pair on its way to the output.
  typedef struct packed {
    logic [GENE_W-1:0] position;
    logic [GENE_W-1:0] first;
    logic [GENE_W-1:0] second;
    logic              crossed;
    logic              last;
  } ocx_result_t;

endpackage

`default_nettype wire

/* src/order_crossover_permutation.sv */
// Top level of the order crossover block: configuration, parent loading and
// the crossover decision. Depends on ocx_pkg, ocx_ram and ocx_seq.
`default_nettype none

// Usage
// Gene pairs are sent as command transactions: a pair is taken at a rising
// edge where start is high and busy is low, one per cycle while loading. The
// pair that fills the last position (effective gene count minus one) also
// carries chance and the two cut points; with it the block decides whether to
// cross and raises busy. After the final pair the block produces one result
// transaction per position of the effective gene count, each on the result
// ports for a single cycle with valid_o high; last_gene_o marks the final one.
// The receiver cannot stall, so results simply appear on schedule. The fill
// reads the parent memory once per cycle for each child in turn, and emission
// needs two reads of the single child memory port per position. The last
// result is on the ports in the first cycle with busy low. Loading runs at
// one pair per cycle.
// Configuration writes (gene_count at index 0, cross_threshold at index 1)
// are always ready and must only be made while the block is idle.
// Reset restores both registers, the load position and the crossover count;
// the gene memories need no clearing, since every entry used is written first.
module order_crossover_permutation #(
  parameter int unsigned MAX_GENES = 64
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [ocx_pkg::GENE_W-1:0]     first_parent_gene_i,
  input  wire logic [ocx_pkg::GENE_W-1:0]     second_parent_gene_i,
  input  wire logic [ocx_pkg::CHANCE_W-1:0]   chance_i,
  input  wire logic [ocx_pkg::GENE_W-1:0]     cut_one_i,
  input  wire logic [ocx_pkg::GENE_W-1:0]     cut_two_i,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [ocx_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [ocx_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                                valid_o,
  output logic      [ocx_pkg::GENE_W-1:0]     position_o,
  output logic      [ocx_pkg::GENE_W-1:0]     first_child_gene_o,
  output logic      [ocx_pkg::GENE_W-1:0]     second_child_gene_o,
  output logic                                crossed_o,
  output logic                                last_gene_o,
  output logic      [ocx_pkg::TOTAL_W-1:0]    crossover_count_o
);

  import ocx_pkg::*;

  // Usable genes: the parameter, but never beyond what a 6-bit gene indexes.
  localparam int unsigned LIMIT = (MAX_GENES < GENE_SLOTS) ? MAX_GENES : GENE_SLOTS;
  localparam int unsigned AW    = $clog2(LIMIT);

  logic [CNT_W-1:0]   gene_count_q;
  logic [THR_W-1:0]   threshold_q;
  logic [GENE_W-1:0]  load_pos_q;
  logic [TOTAL_W-1:0] total_q;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_m1;
  logic [CNT_W-1:0]  cut_a;
  logic [CNT_W-1:0]  cut_b;
  logic              accept;
  logic              final_pair;
  logic              cross_now;
  ocx_cmd_t          cmd;

  logic              seq_busy;
  logic [AW-1:0]     p_raddr;
  logic [PAIR_W-1:0] p_rdata;
  logic              c_we;
  logic [AW:0]       c_waddr;
  logic [GENE_W-1:0] c_wdata;
  logic [AW:0]       c_raddr;
  logic [GENE_W-1:0] c_rdata;
  logic              res_valid;
  ocx_result_t       res;

  // A gene count of zero means one; anything above the limit means the limit.
  always_comb begin
    if (gene_count_q == '0)                count = CNT_W'(1);
    else if (gene_count_q > CNT_W'(LIMIT)) count = CNT_W'(LIMIT);
    else                                   count = gene_count_q;
  end

  assign count_m1   = count - CNT_W'(1);
  assign accept     = start && !seq_busy;
  // At or past the last position counts as final, even if the count shrank.
  assign final_pair = (({1'b0, load_pos_q} + CNT_W'(1)) >= count);
  assign cross_now  = ({1'b0, chance_i} < threshold_q);

  // Clamp both cuts into range, then order them so lo <= hi.
  always_comb begin
    cut_a = ({1'b0, cut_one_i} > count_m1) ? count_m1 : {1'b0, cut_one_i};
    cut_b = ({1'b0, cut_two_i} > count_m1) ? count_m1 : {1'b0, cut_two_i};
    cmd.crossed = cross_now;
    cmd.count   = count;
    if (cut_a > cut_b) begin
      cmd.lo = cut_b[GENE_W-1:0];
      cmd.hi = cut_a[GENE_W-1:0];
    end else begin
      cmd.lo = cut_a[GENE_W-1:0];
      cmd.hi = cut_b[GENE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gene_count_q <= GENE_COUNT_RESET;
      threshold_q  <= THRESHOLD_RESET;
      load_pos_q   <= '0;
      total_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_GENE_COUNT:      gene_count_q <= cfg_data_i[CNT_W-1:0];
          REG_CROSS_THRESHOLD: threshold_q  <= cfg_data_i[THR_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (final_pair) begin
          load_pos_q <= '0;
          if (cross_now) total_q <= total_q + TOTAL_W'(1);
        end else begin
          load_pos_q <= load_pos_q + GENE_W'(1);
        end
      end
    end
  end

  // Parent store: both parents side by side, first parent in the upper half.
  ocx_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (LIMIT)
  ) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (load_pos_q[AW-1:0]),
    .wdata_i ({first_parent_gene_i, second_parent_gene_i}),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  // Child store: first child in the lower half, second child in the upper.
  ocx_ram #(
    .WIDTH (GENE_W),
    .DEPTH (2 << AW)
  ) u_child_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  ocx_seq #(
    .LIMIT (LIMIT),
    .AW    (AW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept && final_pair),
    .cmd_i       (cmd),
    .busy_o      (seq_busy),
    .p_raddr_o   (p_raddr),
    .p_rdata_i   (p_rdata),
    .c_we_o      (c_we),
    .c_waddr_o   (c_waddr),
    .c_wdata_o   (c_wdata),
    .c_raddr_o   (c_raddr),
    .c_rdata_i   (c_rdata),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign busy                = seq_busy;
  assign cfg_ready_o         = 1'b1;
  assign valid_o             = res_valid;
  assign position_o          = res.position;
  assign first_child_gene_o  = res.first;
  assign second_child_gene_o = res.second;
  assign crossed_o           = res.crossed;
  assign last_gene_o         = res.last;
  assign crossover_count_o   = total_q;

endmodule

`default_nettype wire

/* src/ocx_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; used for the parent and child stores.
`default_nettype none

module ocx_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* src/ocx_seq.sv */
// Fill and emit sequencer: for a crossed set it builds both children in the
// child memory, then streams them out; an uncrossed set streams the parents.
// Depends on ocx_pkg; drives the parent read port and the child memory.
`default_nettype none

module ocx_seq #(
  parameter int unsigned LIMIT = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire ocx_pkg::ocx_cmd_t             cmd_i,
  output logic                               busy_o,
  output logic      [AW-1:0]                 p_raddr_o,
  input  wire logic [ocx_pkg::PAIR_W-1:0]    p_rdata_i,
  output logic                               c_we_o,
  output logic      [AW:0]                   c_waddr_o,
  output logic      [ocx_pkg::GENE_W-1:0]    c_wdata_o,
  output logic      [AW:0]                   c_raddr_o,
  input  wire logic [ocx_pkg::GENE_W-1:0]    c_rdata_i,
  output logic                               res_valid_o,
  output ocx_pkg::ocx_result_t               res_o
);

  import ocx_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_COPY  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_EMIT  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;

  localparam logic [1:0] K_COPY   = 2'd0;
  localparam logic [1:0] K_SCAN   = 2'd1;
  localparam logic [1:0] K_EMIT_A = 2'd2;
  localparam logic [1:0] K_EMIT_B = 2'd3;

  function automatic logic [GENE_W-1:0] wrap_inc(input logic [GENE_W-1:0] x,
                                                 input logic [CNT_W-1:0]  n);
    logic [CNT_W-1:0] s;
    s = {1'b0, x} + CNT_W'(1);
    wrap_inc = (s == n) ? '0 : s[GENE_W-1:0];
  endfunction

  logic [2:0]            state_q, state_d;
  ocx_cmd_t              cmd_q, cmd_d;
  logic                  sel_q, sel_d;
  logic [GENE_W-1:0]     iss_q, iss_d;
  logic [GENE_W-1:0]     dst_q, dst_d;
  logic [CNT_W-1:0]      scanned_q, scanned_d;
  logic                  ph_q, ph_d;
  logic [GENE_SLOTS-1:0] marks_q, marks_d;
  logic [LIMIT-1:0]      fill0_q, fill0_d;
  logic [LIMIT-1:0]      fill1_q, fill1_d;
  logic [GENE_W-1:0]     hold_c_q, hold_c_d;
  logic [PAIR_W-1:0]     hold_p_q, hold_p_d;
  logic                  s1_v_q, s1_v_d;
  logic [1:0]            s1_kind_q, s1_kind_d;
  logic [GENE_W-1:0]     s1_pos_q, s1_pos_d;
  logic                  res_valid_q, res_valid_d;
  ocx_result_t           res_q, res_d;

  logic [GENE_W-1:0] own_gene;
  logic [GENE_W-1:0] other_gene;
  logic              stop;

  assign own_gene   = sel_q ? p_rdata_i[GENE_W-1:0] : p_rdata_i[PAIR_W-1:GENE_W];
  assign other_gene = sel_q ? p_rdata_i[PAIR_W-1:GENE_W] : p_rdata_i[GENE_W-1:0];

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    sel_d       = sel_q;
    iss_d       = iss_q;
    dst_d       = dst_q;
    scanned_d   = scanned_q;
    ph_d        = ph_q;
    marks_d     = marks_q;
    fill0_d     = fill0_q;
    fill1_d     = fill1_q;
    hold_c_d    = hold_c_q;
    hold_p_d    = hold_p_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    s1_v_d      = 1'b0;
    s1_kind_d   = K_COPY;
    s1_pos_d    = iss_q;
    c_we_o      = 1'b0;
    c_waddr_o   = '0;
    c_wdata_o   = '0;
    stop        = 1'b0;

    // Second stage: the read data issued last cycle is back.
    if (s1_v_q) begin
      case (s1_kind_q)
        K_COPY: begin
          c_we_o    = 1'b1;
          c_waddr_o = {sel_q, s1_pos_q[AW-1:0]};
          c_wdata_o = own_gene;
          if (sel_q) fill1_d[s1_pos_q[AW-1:0]] = 1'b1;
          else       fill0_d[s1_pos_q[AW-1:0]] = 1'b1;
          marks_d[own_gene] = 1'b1;
        end
        K_SCAN: begin
          if (dst_q == cmd_q.lo || scanned_q == cmd_q.count) begin
            stop = 1'b1;
          end else begin
            scanned_d = scanned_q + CNT_W'(1);
            if (!marks_q[other_gene]) begin
              c_we_o    = 1'b1;
              c_waddr_o = {sel_q, dst_q[AW-1:0]};
              c_wdata_o = other_gene;
              if (sel_q) fill1_d[dst_q[AW-1:0]] = 1'b1;
              else       fill0_d[dst_q[AW-1:0]] = 1'b1;
              dst_d = wrap_inc(dst_q, cmd_q.count);
            end
          end
        end
        K_EMIT_A: begin
          hold_c_d = fill0_q[s1_pos_q[AW-1:0]] ? c_rdata_i : '0;
          hold_p_d = p_rdata_i;
        end
        K_EMIT_B: begin
          res_valid_d    = 1'b1;
          res_d.position = s1_pos_q;
          res_d.crossed  = cmd_q.crossed;
          res_d.last     = (({1'b0, s1_pos_q} + CNT_W'(1)) == cmd_q.count);
          if (cmd_q.crossed) begin
            res_d.first  = hold_c_q;
            res_d.second = fill1_q[s1_pos_q[AW-1:0]] ? c_rdata_i : '0;
          end else begin
            res_d.first  = hold_p_q[PAIR_W-1:GENE_W];
            res_d.second = hold_p_q[GENE_W-1:0];
          end
        end
        default: ;
      endcase
    end

    // First stage: pick the next read and advance the sequence.
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_d   = cmd_i;
          sel_d   = 1'b0;
          ph_d    = 1'b0;
          marks_d = '0;
          fill0_d = '0;
          fill1_d = '0;
          if (cmd_i.crossed) begin
            state_d = ST_COPY;
            iss_d   = cmd_i.lo;
          end else begin
            state_d = ST_EMIT;
            iss_d   = '0;
          end
        end
      end
      ST_COPY: begin
        s1_v_d    = 1'b1;
        s1_kind_d = K_COPY;
        if (iss_q == cmd_q.hi) begin
          state_d   = ST_SCAN;
          iss_d     = wrap_inc(cmd_q.hi, cmd_q.count);
          dst_d     = wrap_inc(cmd_q.hi, cmd_q.count);
          scanned_d = '0;
        end else begin
          iss_d = iss_q + GENE_W'(1);
        end
      end
      ST_SCAN: begin
        if (stop) begin
          if (!sel_q) begin
            sel_d   = 1'b1;
            marks_d = '0;
            iss_d   = cmd_q.lo;
            state_d = ST_COPY;
          end else begin
            state_d = ST_EMIT;
            iss_d   = '0;
            ph_d    = 1'b0;
          end
        end else begin
          s1_v_d    = 1'b1;
          s1_kind_d = K_SCAN;
          iss_d     = wrap_inc(iss_q, cmd_q.count);
        end
      end
      ST_EMIT: begin
        s1_v_d    = 1'b1;
        s1_kind_d = ph_q ? K_EMIT_B : K_EMIT_A;
        ph_d      = ~ph_q;
        if (ph_q) begin
          if (({1'b0, iss_q} + CNT_W'(1)) == cmd_q.count) state_d = ST_DRAIN;
          else                                            iss_d   = iss_q + GENE_W'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      s1_v_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      s1_v_q      <= s1_v_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    sel_q     <= sel_d;
    iss_q     <= iss_d;
    dst_q     <= dst_d;
    scanned_q <= scanned_d;
    ph_q      <= ph_d;
    marks_q   <= marks_d;
    fill0_q   <= fill0_d;
    fill1_q   <= fill1_d;
    hold_c_q  <= hold_c_d;
    hold_p_q  <= hold_p_d;
    s1_kind_q <= s1_kind_d;
    s1_pos_q  <= s1_pos_d;
    res_q     <= res_d;
  end

  assign busy_o      = (state_q != ST_IDLE);
  assign p_raddr_o   = iss_q[AW-1:0];
  assign c_raddr_o   = {ph_q, iss_q[AW-1:0]};
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

/* sim/tb.sv */
// Self-checking testbench for the order crossover block: drives gene-pair transactions,
// predicts both children of every parent set and checks each child-gene result.
// Depends on ocx_pkg and the order_crossover_permutation RTL; reads no files.
`default_nettype none

module tb;
  import ocx_pkg::*;

  localparam int unsigned MAX_GENES    = 64;
  localparam int unsigned ITEM_GOAL    = 330;
  localparam int unsigned LIMIT_CYCLES = 400_000;

  // One parent set as the block stores it: element i is the gene at position i.
  typedef logic [GENE_SLOTS-1:0][GENE_W-1:0] genome_t;

  // One command transaction: a gene pair plus the decision inputs that only
  // matter on the final pair of a set.
  typedef struct packed {
    logic [GENE_W-1:0]   first_gene;
    logic [GENE_W-1:0]   second_gene;
    logic [CHANCE_W-1:0] chance;
    logic [GENE_W-1:0]   cut_one;
    logic [GENE_W-1:0]   cut_two;
  } pair_item_t;

  // One child-gene result as the block should emit it.
  typedef struct packed {
    logic [GENE_W-1:0]  position;
    logic [GENE_W-1:0]  first_child;
    logic [GENE_W-1:0]  second_child;
    logic               crossed;
    logic               last_gene;
    logic [TOTAL_W-1:0] crossover_count;
  } child_gene_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [GENE_W-1:0]     first_parent_gene_i;
  logic [GENE_W-1:0]     second_parent_gene_i;
  logic [CHANCE_W-1:0]   chance_i;
  logic [GENE_W-1:0]     cut_one_i;
  logic [GENE_W-1:0]     cut_two_i;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  valid_o;
  logic [GENE_W-1:0]     position_o;
  logic [GENE_W-1:0]     first_child_gene_o;
  logic [GENE_W-1:0]     second_child_gene_o;
  logic                  crossed_o;
  logic                  last_gene_o;
  logic [TOTAL_W-1:0]    crossover_count_o;

  order_crossover_permutation #(
    .MAX_GENES(MAX_GENES)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .first_parent_gene_i (first_parent_gene_i),
    .second_parent_gene_i(second_parent_gene_i),
    .chance_i            (chance_i),
    .cut_one_i           (cut_one_i),
    .cut_two_i           (cut_two_i),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .valid_o             (valid_o),
    .position_o          (position_o),
    .first_child_gene_o  (first_child_gene_o),
    .second_child_gene_o (second_child_gene_o),
    .crossed_o           (crossed_o),
    .last_gene_o         (last_gene_o),
    .crossover_count_o   (crossover_count_o)
  );

  // Mirror of the block's architectural state, updated on every accepted
  // transaction and every configuration write.
  logic [CNT_W-1:0]   gene_count_q;
  logic [THR_W-1:0]   threshold_q;
  genome_t            first_parent_mirror;
  genome_t            second_parent_mirror;
  int unsigned        load_pos_q;
  logic [TOTAL_W-1:0] crossover_total_q;

  child_gene_t pending_child_genes[$];

  bit          sender_idles;
  int unsigned items_sent;
  int unsigned sets_done;
  int unsigned sets_crossed;
  int unsigned genes_checked;
  int unsigned mismatches;
  int unsigned cycle_count;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog. Hitting the cycle limit means the block stopped answering.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Effective gene count: zero behaves as one, anything past the store size
  // behaves as the store size.
  function automatic int unsigned genes_in_use();
    int unsigned n;
    int unsigned cap;
    cap = (MAX_GENES < GENE_SLOTS) ? MAX_GENES : GENE_SLOTS;
    n = gene_count_q;
    if (n == 0) n = 1;
    if (n > cap) n = cap;
    return n;
  endfunction

  // Builds one OX child: the own parent's segment lo..hi is kept, then the
  // other parent's genes are placed cyclically from hi+1, skipping any gene
  // already present. The scan gives up after one full lap, so malformed
  // parents leave holes that read as zero.
  function automatic genome_t order_fill(input genome_t own, input genome_t other,
                                         input int unsigned n, input int unsigned lo,
                                         input int unsigned hi);
    genome_t           child;
    logic [63:0]       taken;
    logic [GENE_W-1:0] g;
    int unsigned       i;
    int unsigned       src;
    int unsigned       dst;
    int unsigned       scanned;
    child = '0;
    taken = '0;
    for (i = lo; i <= hi; i++) begin
      child[i] = own[i];
      taken[own[i]] = 1'b1;
    end
    src = (hi + 1) % n;
    dst = (hi + 1) % n;
    scanned = 0;
    while (dst != lo && scanned < n) begin
      g = other[src];
      if (!taken[g]) begin
        child[dst] = g;
        dst = (dst + 1) % n;
      end
      src = (src + 1) % n;
      scanned++;
    end
    return child;
  endfunction

  // Applies one accepted transaction to the mirror. A pair that lands on the
  // last position (or past it, if the count was lowered mid-load) closes the
  // set: the cuts are clamped and ordered, the crossover decision is taken and
  // one expected result per gene position is queued.
  function automatic void predict_children(input pair_item_t item);
    int unsigned n;
    int unsigned pos;
    int unsigned lo;
    int unsigned hi;
    int unsigned t;
    int unsigned i;
    logic        crossed;
    genome_t     first_kid;
    genome_t     second_kid;
    child_gene_t result;
    n = genes_in_use();
    pos = load_pos_q & 63;
    first_parent_mirror[pos] = item.first_gene;
    second_parent_mirror[pos] = item.second_gene;
    if (pos + 1 < n) begin
      load_pos_q = pos + 1;
      return;
    end
    load_pos_q = 0;
    lo = item.cut_one;
    hi = item.cut_two;
    if (lo > n - 1) lo = n - 1;
    if (hi > n - 1) hi = n - 1;
    if (lo > hi) begin
      t = lo;
      lo = hi;
      hi = t;
    end
    crossed = ({1'b0, item.chance} < threshold_q);
    if (crossed) begin
      crossover_total_q = crossover_total_q + 1;
      first_kid = order_fill(first_parent_mirror, second_parent_mirror, n, lo, hi);
      second_kid = order_fill(second_parent_mirror, first_parent_mirror, n, lo, hi);
      sets_crossed++;
    end else begin
      first_kid = first_parent_mirror;
      second_kid = second_parent_mirror;
    end
    sets_done++;
    for (i = 0; i < n; i++) begin
      result.position = GENE_W'(i);
      result.first_child = first_kid[i];
      result.second_child = second_kid[i];
      result.crossed = crossed;
      result.last_gene = (i + 1 == n);
      result.crossover_count = crossover_total_q;
      pending_child_genes.push_back(result);
    end
  endfunction

  function automatic void compare_field(input string field, input logic [TOTAL_W-1:0] want,
                                        input logic [TOTAL_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  // Result checker. A result sits on the ports for one cycle and is taken at
  // the rising edge that ends it; the receiver has no way to stall.
  always @(posedge clk_i) begin : check_results
    child_gene_t want;
    if (rst_ni && valid_o) begin
      if (pending_child_genes.size() == 0) begin
        $error("unexpected child-gene result at position %0d", position_o);
        mismatches++;
      end else begin
        want = pending_child_genes.pop_front();
        compare_field("position", want.position, position_o);
        compare_field("first_child_gene", want.first_child, first_child_gene_o);
        compare_field("second_child_gene", want.second_child, second_child_gene_o);
        compare_field("crossed", want.crossed, crossed_o);
        compare_field("last_gene", want.last_gene, last_gene_o);
        compare_field("crossover_count", want.crossover_count, crossover_count_o);
        genes_checked++;
      end
    end
  end

  // Sends one gene-pair transaction. Start is left high on return so that
  // back-to-back pairs load at full rate; with sender_idles set, a random gap
  // may lower it first. The pair is taken at the first rising edge with busy low.
  task automatic load_pair(input pair_item_t item);
    if (sender_idles && $urandom_range(99) < 35) begin
      @(negedge clk_i);
      start <= 1'b0;
      while ($urandom_range(99) < 35) @(negedge clk_i);
    end
    @(negedge clk_i);
    start                <= 1'b1;
    first_parent_gene_i  <= item.first_gene;
    second_parent_gene_i <= item.second_gene;
    chance_i             <= item.chance;
    cut_one_i            <= item.cut_one;
    cut_two_i            <= item.cut_two;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_children(item);
    items_sent++;
  endtask

  // Sends a whole parent set of n pairs. Only the last pair carries the real
  // decision inputs; the others carry random values the block must ignore.
  task automatic send_parent_set(input genome_t first, input genome_t second,
                                 input int unsigned n, input logic [CHANCE_W-1:0] chance,
                                 input logic [GENE_W-1:0] cut_one,
                                 input logic [GENE_W-1:0] cut_two);
    pair_item_t  item;
    int unsigned i;
    for (i = 0; i < n; i++) begin
      item.first_gene = first[i];
      item.second_gene = second[i];
      if (i == n - 1) begin
        item.chance = chance;
        item.cut_one = cut_one;
        item.cut_two = cut_two;
      end else begin
        item.chance = $urandom_range(16'hFFFF);
        item.cut_one = $urandom_range(63);
        item.cut_two = $urandom_range(63);
      end
      load_pair(item);
    end
  endtask

  // Lowers start, waits for every expected result, then lets the block finish
  // any internal work before a configuration write or the end of the run.
  task automatic settle_block();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_child_genes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (index == REG_GENE_COUNT) gene_count_q = value[CNT_W-1:0];
    else if (index == REG_CROSS_THRESHOLD) threshold_q = value[THR_W-1:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // A random parent of n genes: a shuffled permutation of 0..n-1 when well
  // formed, otherwise arbitrary 6-bit genes with repeats and out-of-range values.
  function automatic genome_t draw_parent(input int unsigned n, input bit well_formed);
    genome_t           g;
    logic [GENE_W-1:0] t;
    int unsigned       i;
    int unsigned       j;
    for (i = 0; i < GENE_SLOTS; i++) begin
      g[i] = (well_formed && i < n) ? GENE_W'(i) : GENE_W'($urandom_range(63));
    end
    if (well_formed) begin
      for (i = n; i > 1; i--) begin
        j = $urandom_range(i - 1);
        t = g[i - 1];
        g[i - 1] = g[j];
        g[j] = t;
      end
    end
    return g;
  endfunction

  // Reset values: a full 64-gene set at the default count and threshold, sent
  // back to back with no idling at all.
  task automatic test_reset_defaults();
    sender_idles = 1'b0;
    send_parent_set(draw_parent(64, 1'b1), draw_parent(64, 1'b1), genes_in_use(),
                    $urandom_range(16'hFFFF), $urandom_range(63), $urandom_range(63));
    settle_block();
    sender_idles = 1'b1;
  endtask

  // The same small parents once crossed (chance zero) and once copied (chance
  // at its maximum, above the default threshold).
  task automatic test_copy_and_cross();
    genome_t first;
    genome_t second;
    first = '0;
    second = '0;
    // Literals list the highest position first.
    first[3:0] = {6'd3, 6'd2, 6'd1, 6'd0};
    second[3:0] = {6'd1, 6'd3, 6'd0, 6'd2};
    write_register(REG_GENE_COUNT, CFG_DATA_W'(4));
    send_parent_set(first, second, 4, '0, 6'd1, 6'd2);
    send_parent_set(first, second, 4, '1, 6'd2, 6'd1);
    settle_block();
  endtask

  // Cut points past the end are clamped to the last position and then put in
  // order, here giving a segment that covers the whole child.
  task automatic test_cut_clamping();
    genome_t first;
    genome_t second;
    first = '0;
    second = '0;
    first[2:0] = {6'd1, 6'd0, 6'd2};
    second[2:0] = {6'd0, 6'd2, 6'd1};
    write_register(REG_GENE_COUNT, CFG_DATA_W'(3));
    send_parent_set(first, second, 3, '0, 6'd63, 6'd0);
    settle_block();
  endtask

  // A count of zero behaves as one gene: every pair closes a set. The extreme
  // gene values ride along.
  task automatic test_zero_gene_count();
    write_register(REG_GENE_COUNT, CFG_DATA_W'(0));
    send_parent_set({GENE_SLOTS{6'd63}}, {GENE_SLOTS{6'd63}}, 1, '0, 6'd63, 6'd63);
    send_parent_set('0, '0, 1, '1, 6'd0, 6'd0);
    settle_block();
  endtask

  // Threshold zero never crosses, even for chance zero; the 65536 threshold
  // always crosses, even for the largest chance.
  task automatic test_threshold_limits();
    genome_t first;
    genome_t second;
    first = '0;
    second = '0;
    first[1:0] = {6'd0, 6'd1};
    second[1:0] = {6'd1, 6'd0};
    write_register(REG_GENE_COUNT, CFG_DATA_W'(2));
    write_register(REG_CROSS_THRESHOLD, CFG_DATA_W'(0));
    send_parent_set(first, second, 2, '0, 6'd0, 6'd1);
    settle_block();
    write_register(REG_CROSS_THRESHOLD, CFG_DATA_W'(65536));
    send_parent_set(first, second, 2, '1, 6'd1, 6'd0);
    settle_block();
  endtask

  // Parents with repeated genes and genes beyond the count: the fill scan
  // stops after one lap and leaves zero in the positions it could not fill.
  task automatic test_malformed_parents();
    genome_t first;
    genome_t second;
    first = '0;
    second = '0;
    first[3:0] = {6'd0, 6'd63, 6'd3, 6'd3};
    second[3:0] = {6'd62, 6'd1, 6'd1, 6'd5};
    write_register(REG_GENE_COUNT, CFG_DATA_W'(4));
    send_parent_set(first, second, 4, '0, 6'd1, 6'd1);
    settle_block();
  endtask

  // The count drops below the load position while a set is half loaded: the
  // next pair closes the set at the new, smaller size.
  task automatic test_count_lowered_mid_load();
    pair_item_t item;
    int unsigned i;
    write_register(REG_GENE_COUNT, CFG_DATA_W'(6));
    for (i = 0; i < 5; i++) begin
      if (i == 4) begin
        settle_block();
        write_register(REG_GENE_COUNT, CFG_DATA_W'(2));
      end
      item.first_gene = $urandom_range(63);
      item.second_gene = $urandom_range(63);
      item.chance = 16'd100;
      item.cut_one = $urandom_range(63);
      item.cut_two = $urandom_range(63);
      load_pair(item);
    end
    settle_block();
  endtask

  // Random phases. Each one picks a count and a threshold (extremes included,
  // the first phase a count past the store size), then sends a few sets. Most
  // sets are well-formed permutations with random content; one in ten is noise.
  task automatic test_random_sets();
    int unsigned   phase;
    int unsigned   n;
    int unsigned   sets;
    bit            well_formed;
    logic [6:0]    count;
    logic [16:0]   threshold;
    logic [GENE_W-1:0] cut_a;
    logic [GENE_W-1:0] cut_b;
    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      if (phase == 0) count = 7'd127;
      else if ($urandom_range(7) == 0) count = $urandom_range(40, 13);
      else count = $urandom_range(12, 1);
      case ($urandom_range(5))
        0: threshold = 17'd0;
        1: threshold = 17'd65536;
        2: threshold = 17'h1FFFF;
        3: threshold = $urandom_range(65535);
        default: threshold = 17'd58982;
      endcase
      write_register(REG_GENE_COUNT, CFG_DATA_W'(count));
      write_register(REG_CROSS_THRESHOLD, CFG_DATA_W'(threshold));
      n = genes_in_use();
      // Every fourth phase runs flat out to keep a long idle-free stretch.
      sender_idles = (phase % 4 != 2);
      sets = (n > 16) ? 1 : $urandom_range(5, 2);
      repeat (sets) begin
        well_formed = ($urandom_range(9) != 0);
        cut_a = $urandom_range(1) ? $urandom_range(63) : $urandom_range(n - 1);
        cut_b = $urandom_range(1) ? $urandom_range(63) : $urandom_range(n - 1);
        send_parent_set(draw_parent(n, well_formed), draw_parent(n, well_formed), n,
                        $urandom_range(16'hFFFF), cut_a, cut_b);
      end
      settle_block();
      phase++;
    end
    sender_idles = 1'b1;
  endtask

  initial begin
    rst_ni               = 1'b0;
    start                = 1'b0;
    first_parent_gene_i  = '0;
    second_parent_gene_i = '0;
    chance_i             = '0;
    cut_one_i            = '0;
    cut_two_i            = '0;
    cfg_valid_i          = 1'b0;
    cfg_index_i          = REG_GENE_COUNT;
    cfg_data_i           = '0;
    gene_count_q         = GENE_COUNT_RESET;
    threshold_q          = THRESHOLD_RESET;
    first_parent_mirror  = '0;
    second_parent_mirror = '0;
    load_pos_q           = 0;
    crossover_total_q    = '0;
    sender_idles         = 1'b1;
    items_sent           = 0;
    sets_done            = 0;
    sets_crossed         = 0;
    genes_checked        = 0;
    mismatches           = 0;
    cycle_count          = 0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_copy_and_cross();
    test_cut_clamping();
    test_zero_gene_count();
    test_threshold_limits();
    test_malformed_parents();
    test_count_lowered_mid_load();
    test_random_sets();

    settle_block();
    if (pending_child_genes.size() != 0) begin
      $error("%0d expected child-gene results never arrived", pending_child_genes.size());
      mismatches++;
    end
    $display("Run covered %0d pair transactions in %0d parent sets, %0d of them crossed.",
             items_sent, sets_done, sets_crossed);
    $display("%0d child-gene results checked; counts 0 to 127 and thresholds 0 to max used.",
             genes_checked);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
